>>> sv/bmsort_pkg.sv
// Package for the bottom-up merge sorter: payload word types and sequencer states.
// No dependencies. Imported by sv/bottom_up_merge_sort.sv.
`timescale 1ns / 1ps
`default_nettype none

package bmsort_pkg;

  // One loaded value. A set bit in last_in closes the set.
  typedef struct packed {
    logic signed [31:0] value;
    logic               last_in;
  } item_t;

  // One sorted result word.
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MERGE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> sv/bottom_up_merge_sort.sv
// Bottom-up merge sorter top level: load, merge passes and emit around two store memories.
// Depends on bmsort_pkg (item_t, result_t, state_t).
// Load: one word per cycle while busy is low; busy rises after the word that carries last_in.
// Sort: P = ceil(log2(n)) merge passes for n words stored, each set up in ST_PRIME. Then n results
// on consecutive cycles, one strobe each. Sorting is paced by the single merge unit, which writes
// one word per cycle; busy stays high, so no new set is taken until the last result is out.
// Reset (rst, synchronous) clears the sequencer, word count and drop flag; store contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module bottom_up_merge_sort #(
  parameter int CAPACITY = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  bmsort_pkg::item_t    item,
  output logic                 strobe,
  output bmsort_pkg::result_t  result
);

  import bmsort_pkg::*;

  // Count must hold CAPACITY itself; sums of an index and two run widths need two more bits.
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int WID_W  = CNT_W + 1;
  localparam int SUM_W  = CNT_W + 2;

  // Two stores. The merge reads the source store at the left and right run heads and
  // writes the destination store; src_sel swaps their roles after every pass.
  logic signed [31:0] mem_a [CAPACITY];
  logic signed [31:0] mem_b [CAPACITY];
  logic signed [31:0] a_q_l, a_q_r, b_q_l, b_q_r;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;     // words stored in the current set
  logic               dropped, dropped_next; // a word was dropped from the current set
  logic               ovf, ovf_next;         // overflow mark for the set being sorted
  logic [CNT_W-1:0]   n, n_next;             // size of the set being sorted
  logic               src_sel, src_sel_next; // 0: mem_a is source, 1: mem_b is source
  logic [WID_W-1:0]   width, width_next;     // current run width
  logic [CNT_W-1:0]   l, l_next;             // left head; also the emit index
  logic [CNT_W-1:0]   r, r_next;             // right head
  logic [CNT_W-1:0]   k, k_next;             // merge write index
  logic [CNT_W-1:0]   mid, mid_next;         // end of left run
  logic [CNT_W-1:0]   hi, hi_next;           // end of right run

  logic signed [31:0] dl, dr, wdata;
  logic               take_l, seg_done, pass_done, is_full, accept, last_emit;
  logic               a_we, b_we;
  logic [ADDR_W-1:0]  a_waddr;
  logic signed [31:0] a_wdata;
  logic [SUM_W-1:0]   sum_mid, sum_hi, n_wide;

  // Heads of the two runs, registered out of the source store.
  assign dl = src_sel ? b_q_l : a_q_l;
  assign dr = src_sel ? b_q_r : a_q_r;

  assign accept    = start && !busy;
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign n_wide    = SUM_W'(n);
  assign last_emit = (l == n - CNT_W'(1));

  // Left wins ties, which keeps the sort stable.
  assign take_l    = (l < mid) && ((r >= hi) || (dl <= dr));
  assign wdata     = take_l ? dl : dr;
  assign seg_done  = ((k + CNT_W'(1)) == hi);
  assign pass_done = seg_done && (hi == n);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item.last_in) state_next = ST_PRIME;
      end
      ST_PRIME: begin
        state_next = (width >= WID_W'(n)) ? ST_EMIT : ST_MERGE;
      end
      ST_MERGE: begin
        if (pass_done) state_next = ST_PRIME;
      end
      ST_EMIT: begin
        if (last_emit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_next   = count;
    dropped_next = dropped;
    ovf_next     = ovf;
    n_next       = n;
    src_sel_next = src_sel;
    width_next   = width;
    l_next       = l;
    r_next       = r;
    k_next       = k;
    mid_next     = mid;
    hi_next      = hi;
    a_we         = 1'b0;
    b_we         = 1'b0;
    a_waddr      = k[ADDR_W-1:0];
    a_wdata      = wdata;
    sum_mid      = SUM_W'(hi) + SUM_W'(width);
    sum_hi       = SUM_W'(hi) + (SUM_W'(width) << 1);
    busy         = (state != ST_IDLE);
    strobe       = 1'b0;
    result.sorted_value = dl;
    result.last_out     = last_emit;
    result.overflow     = ovf;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          // Store the word while there is room, else drop it and mark the set.
          if (!is_full) begin
            a_we       = 1'b1;
            a_waddr    = count[ADDR_W-1:0];
            a_wdata    = item.value;
            count_next = count + CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (item.last_in) begin
            n_next       = is_full ? count : count + CNT_W'(1);
            ovf_next     = dropped || is_full;
            count_next   = '0;
            dropped_next = 1'b0;
            src_sel_next = 1'b0;
            width_next   = WID_W'(1);
          end
        end
      end
      ST_PRIME: begin
        // Set up the first pair of runs of a pass, or the emit index.
        sum_mid = SUM_W'(width);
        sum_hi  = SUM_W'(width) << 1;
        l_next  = '0;
        k_next  = '0;
        if (width < WID_W'(n)) begin
          mid_next = (sum_mid < n_wide) ? sum_mid[CNT_W-1:0] : n;
          hi_next  = (sum_hi < n_wide) ? sum_hi[CNT_W-1:0] : n;
          r_next   = mid_next;
        end
      end
      ST_MERGE: begin
        // Write the winner to the destination store and advance its head.
        if (src_sel) a_we = 1'b1;
        else b_we = 1'b1;
        l_next = l + CNT_W'(take_l);
        r_next = r + CNT_W'(!take_l);
        k_next = k + CNT_W'(1);
        if (pass_done) begin
          width_next   = width << 1;
          src_sel_next = !src_sel;
        end else if (seg_done) begin
          // Move to the next pair of runs.
          mid_next = (sum_mid < n_wide) ? sum_mid[CNT_W-1:0] : n;
          hi_next  = (sum_hi < n_wide) ? sum_hi[CNT_W-1:0] : n;
          l_next   = hi;
          r_next   = mid_next;
        end
      end
      ST_EMIT: begin
        // The read issued on the previous edge is the word shown this cycle.
        strobe = 1'b1;
        l_next = l + CNT_W'(1);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Store memories: one write port, two registered read ports at the next head addresses.
  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    a_q_l <= mem_a[l_next[ADDR_W-1:0]];
    a_q_r <= mem_a[r_next[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[k[ADDR_W-1:0]] <= wdata;
    b_q_l <= mem_b[l_next[ADDR_W-1:0]];
    b_q_r <= mem_b[r_next[ADDR_W-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  // Sort registers; only meaningful once a set is closed.
  always_ff @(posedge clk) begin
    ovf     <= ovf_next;
    n       <= n_next;
    src_sel <= src_sel_next;
    width   <= width_next;
    l       <= l_next;
    r       <= r_next;
    k       <= k_next;
    mid     <= mid_next;
    hi      <= hi_next;
  end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for bottom_up_merge_sort: loads sets of words, predicts the sorted
// output of each set and compares every result word as it is strobed out.
// Depends on bmsort_pkg (item_t, result_t) and sv/bottom_up_merge_sort.sv.
`timescale 1ns / 1ps

module tb_top;
  import bmsort_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int RANDOM_WORDS  = 200;
  localparam int STALL_LIMIT   = 2000;  // cycles with no word moving in either direction
  localparam int DRAIN_CYCLES  = 120;   // one full 16-word sort and emit, with margin

  typedef enum int {
    MIX_FULL,    // any 32-bit pattern
    MIX_NARROW,  // a few values around zero, so duplicates are common
    MIX_EDGE     // most negative, most positive, zero and the values beside it
  } value_mix_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  bottom_up_merge_sort #(.CAPACITY(CAPACITY)) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Words waiting to be driven, and sorted words waiting to come out.
  item_t   pending_words[$];
  result_t expected_sorted[$];

  // Predictor copy of the set being loaded.
  logic signed [31:0] loaded_set [CAPACITY];
  int                 loaded_count = 0;
  logic               set_dropped = 1'b0;

  int   total_words = 0;
  int   words_issued = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  logic word_taken = 1'b0;

  // Store the word; on the closing word sort the set and queue one result per stored word.
  task automatic absorb_word(input item_t w);
    int                 i;
    int                 j;
    logic signed [31:0] key;
    result_t            r;
    if (loaded_count < CAPACITY) begin
      loaded_set[loaded_count] = w.value;
      loaded_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (w.last_in) begin
      for (i = 1; i < loaded_count; i++) begin
        key = loaded_set[i];
        j = i - 1;
        while (j >= 0 && loaded_set[j] > key) begin
          loaded_set[j + 1] = loaded_set[j];
          j--;
        end
        loaded_set[j + 1] = key;
      end
      for (i = 0; i < loaded_count; i++) begin
        r.sorted_value = loaded_set[i];
        r.last_out     = (i == loaded_count - 1);
        r.overflow     = set_dropped;
        expected_sorted.push_back(r);
      end
      loaded_count = 0;
      set_dropped  = 1'b0;
    end
  endtask

  function automatic logic signed [31:0] pick_value(input value_mix_t mix);
    logic signed [31:0] v;
    case (mix)
      MIX_NARROW: begin
        v = $signed($urandom_range(0, 6)) - 3;
      end
      MIX_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2:       v = 32'sh0000_0000;
          3:       v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  task automatic queue_word(input logic signed [31:0] v, input logic closes);
    item_t w;
    w.value   = v;
    w.last_in = closes;
    pending_words.push_back(w);
  endtask

  // Sender gap rate: light gaps first, heavy gaps next, then back to back.
  function automatic int sender_gap_pct();
    if (words_issued * 3 < total_words) begin
      return 12;
    end else if (words_issued * 3 < total_words * 2) begin
      return 78;
    end
    return 0;
  endfunction

  // Driver: change inputs on the falling edge; hold a word until the block takes it.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct()) begin
        item         <= pending_words.pop_front();
        start        <= 1'b1;
        words_issued <= words_issued + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: sample on the rising edge, feed accepted words to the predictor, check results.
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= start && !busy;
      if (start && !busy) begin
        absorb_word(item);
      end
      if (strobe) begin
        if (expected_sorted.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value=%0d last=%0b ovf=%0b",
                   $time, result.sorted_value, result.last_out, result.overflow);
          mismatches++;
        end else begin
          if (result.sorted_value !== expected_sorted[0].sorted_value ||
              result.last_out !== expected_sorted[0].last_out ||
              result.overflow !== expected_sorted[0].overflow) begin
            $display({"%0t: mismatch, expected value=%0d last=%0b ovf=%0b,",
                      " actual value=%0d last=%0b ovf=%0b"},
                     $time, expected_sorted[0].sorted_value, expected_sorted[0].last_out,
                     expected_sorted[0].overflow, result.sorted_value, result.last_out,
                     result.overflow);
            mismatches++;
          end
          void'(expected_sorted.pop_front());
        end
      end
    end
  end

  // Watchdog: a sort is quiet while it merges, but a silence that reaches STALL_LIMIT is a hang.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("bottom_up_merge_sort verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         set_len;
    int         k;
    int         random_words;
    value_mix_t mix;

    // Single-word set holding the most negative value.
    queue_word(32'sh8000_0000, 1'b1);
    // Extremes with a duplicate.
    queue_word(32'sh7fff_ffff, 1'b0);
    queue_word(32'sh0000_0000, 1'b0);
    queue_word(-32'sd1, 1'b0);
    queue_word(32'sh8000_0000, 1'b0);
    queue_word(-32'sd1, 1'b1);
    // Reverse order filling the store, then a closing word that gets dropped.
    for (k = 0; k <= CAPACITY; k++) begin
      queue_word(CAPACITY - k, k == CAPACITY);
    end

    // Random sets: mostly well-formed sets within capacity, some that overrun it.
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        set_len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      end else begin
        set_len = $urandom_range(1, CAPACITY);
      end
      case ($urandom_range(0, 3))
        0:       mix = MIX_NARROW;
        1:       mix = MIX_EDGE;
        default: mix = MIX_FULL;
      endcase
      for (k = 0; k < set_len; k++) begin
        queue_word(pick_value(mix), k == set_len - 1);
      end
      random_words += set_len;
    end
    total_words = pending_words.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every word taken, every result seen, then a quiet tail for stray strobes.
    while (pending_words.size() > 0 || start) @(posedge clk);
    while (expected_sorted.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("bottom_up_merge_sort verification clean");
    end else begin
      $display("bottom_up_merge_sort verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bmsort_pkg.sv
sv/bottom_up_merge_sort.sv
sim/tb_top.sv
